@@ hw/rtl/dbu_pkg.sv @@
`timescale 1ns / 1ps
package dbu_pkg;

   localparam int PIXEL_BITS_DEFAULT      = 12;
   localparam int COORD_FRAC_BITS_DEFAULT = 4;
   localparam int SCALE_FRAC_BITS_DEFAULT = 16;

   localparam int SCORE_BITS     = 16;
   localparam int CATEGORY_BITS  = 8;
   localparam int SCALE_INT_BITS = 4;
   localparam int CSR_INDEX_BITS = 3;
   localparam int QUEUE_DEPTH    = 4;

   localparam logic [CATEGORY_BITS-1:0] KEEP_CATEGORY = '0;

   localparam int MIN_SCORE_RESET  = 16384;
   localparam int FRAME_SIZE_RESET = 640;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_MIN_SCORE      = 3'd0,
      REG_INVERSE_SCALE  = 3'd1,
      REG_LEFT_PAD       = 3'd2,
      REG_PAD_TOP        = 3'd3,
      REG_REGION_TOP_ROW = 3'd4,
      REG_FRAME_WIDTH    = 3'd5,
      REG_FRAME_HEIGHT   = 3'd6
   } csr_index_type;

endpackage

@@ hw/rtl/dbu_if.sv @@
`timescale 1ns / 1ps
interface dbu_req_if #(
   parameter int COORD_BITS = dbu_pkg::PIXEL_BITS_DEFAULT + dbu_pkg::COORD_FRAC_BITS_DEFAULT
);
   import dbu_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] left_in;
   logic signed [COORD_BITS-1:0] top_in;
   logic signed [COORD_BITS-1:0] right_in;
   logic signed [COORD_BITS-1:0] bottom_in;
   logic [SCORE_BITS-1:0]        confidence;
   logic [CATEGORY_BITS-1:0]     category;

   modport source (
      output valid, left_in, top_in, right_in, bottom_in, confidence, category,
      input  ready
   );
   modport sink (
      input  valid, left_in, top_in, right_in, bottom_in, confidence, category,
      output ready
   );
endinterface

interface dbu_rsp_if #(
   parameter int PIXEL_BITS = dbu_pkg::PIXEL_BITS_DEFAULT
);
   import dbu_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      kept;
   logic [PIXEL_BITS-1:0]     rect_left;
   logic [PIXEL_BITS-1:0]     rect_top;
   logic [PIXEL_BITS-1:0]     rect_width;
   logic [PIXEL_BITS-1:0]     rect_height;
   logic [2*PIXEL_BITS-1:0]   rect_area;
   logic [PIXEL_BITS:0]       mid_x;
   logic [PIXEL_BITS:0]       mid_y;
   logic [SCORE_BITS-1:0]     score_out;

   modport source (
      output valid, kept, rect_left, rect_top, rect_width, rect_height, rect_area,
             mid_x, mid_y, score_out,
      input  ready
   );
   modport sink (
      input  valid, kept, rect_left, rect_top, rect_width, rect_height, rect_area,
             mid_x, mid_y, score_out,
      output ready
   );
endinterface

@@ hw/rtl/detection_box_unletterbox.sv @@
`timescale 1ns / 1ps
// Detection box un-letterbox. Takes one detector box per item on req and
// returns exactly one result per item on rsp, in order: the box mapped back
// to frame pixels with kept set, or an all-zero result with kept clear when
// the score is below threshold, the class is not 0, or the clamped rectangle
// is empty. Sustained rate is one item per clock while rsp is not stalled:
// four corner multipliers in the first back-end stage take a full box every
// cycle that the pipeline advances. An accepted item passes through the
// queue, then the multiply stage, then round and clamp, then the output
// register. A four-entry queue between the front end and the back end
// keeps input flowing while results wait. Configuration registers are
// written through csr_ and must only be written while no item is in flight;
// an inverse scale of zero acts as 1.0.
module detection_box_unletterbox #(
   parameter int PIXEL_BITS      = dbu_pkg::PIXEL_BITS_DEFAULT,
   parameter int COORD_FRAC_BITS = dbu_pkg::COORD_FRAC_BITS_DEFAULT,
   parameter int SCALE_FRAC_BITS = dbu_pkg::SCALE_FRAC_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   dbu_req_if.sink                             req,
   dbu_rsp_if.source                           rsp,
   input  logic                                csr_write_enable,
   input  logic [dbu_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [((dbu_pkg::SCALE_INT_BITS + SCALE_FRAC_BITS > dbu_pkg::SCORE_BITS) ?
                  (dbu_pkg::SCALE_INT_BITS + SCALE_FRAC_BITS) : dbu_pkg::SCORE_BITS) - 1:0]
                                               csr_write_data
);
   import dbu_pkg::*;

   localparam int SW      = SCALE_INT_BITS + SCALE_FRAC_BITS;
   localparam int DW      = PIXEL_BITS + COORD_FRAC_BITS + 2;
   localparam int ENTRY_W = 1 + SCORE_BITS + 4 * DW;

   logic [SCORE_BITS-1:0] min_score_ff, min_score_in;
   logic [SW-1:0]         inverse_scale_ff, inverse_scale_in;
   logic [PIXEL_BITS-1:0] left_pad_ff, left_pad_in;
   logic [PIXEL_BITS-1:0] pad_top_ff, pad_top_in;
   logic [PIXEL_BITS-1:0] region_top_row_ff, region_top_row_in;
   logic [PIXEL_BITS-1:0] frame_width_ff, frame_width_in;
   logic [PIXEL_BITS-1:0] frame_height_ff, frame_height_in;

   logic               push_valid;
   logic               push_ready;
   logic [ENTRY_W-1:0] push_data;
   logic               pop_valid;
   logic               pop_ready;
   logic [ENTRY_W-1:0] pop_data;

   always_comb begin
      min_score_in       = min_score_ff;
      inverse_scale_in   = inverse_scale_ff;
      left_pad_in        = left_pad_ff;
      pad_top_in         = pad_top_ff;
      region_top_row_in  = region_top_row_ff;
      frame_width_in     = frame_width_ff;
      frame_height_in    = frame_height_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            REG_MIN_SCORE:      min_score_in       = csr_write_data[SCORE_BITS-1:0];
            REG_INVERSE_SCALE:  inverse_scale_in   = csr_write_data[SW-1:0];
            REG_LEFT_PAD:       left_pad_in        = csr_write_data[PIXEL_BITS-1:0];
            REG_PAD_TOP:        pad_top_in         = csr_write_data[PIXEL_BITS-1:0];
            REG_REGION_TOP_ROW: region_top_row_in  = csr_write_data[PIXEL_BITS-1:0];
            REG_FRAME_WIDTH:    frame_width_in     = csr_write_data[PIXEL_BITS-1:0];
            REG_FRAME_HEIGHT:   frame_height_in    = csr_write_data[PIXEL_BITS-1:0];
            default: begin
               // Writes to an unused index are dropped.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_score_ff       <= SCORE_BITS'(MIN_SCORE_RESET);
         inverse_scale_ff   <= SW'(1) << SCALE_FRAC_BITS;
         left_pad_ff        <= '0;
         pad_top_ff         <= '0;
         region_top_row_ff  <= '0;
         frame_width_ff     <= PIXEL_BITS'(FRAME_SIZE_RESET);
         frame_height_ff    <= PIXEL_BITS'(FRAME_SIZE_RESET);
      end else begin
         min_score_ff       <= min_score_in;
         inverse_scale_ff   <= inverse_scale_in;
         left_pad_ff        <= left_pad_in;
         pad_top_ff         <= pad_top_in;
         region_top_row_ff  <= region_top_row_in;
         frame_width_ff     <= frame_width_in;
         frame_height_ff    <= frame_height_in;
      end
   end

   dbu_front #(
      .PIXEL_BITS      (PIXEL_BITS),
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_front (
      .req             (req),
      .min_score       (min_score_ff),
      .left_pad        (left_pad_ff),
      .pad_top         (pad_top_ff),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_data       (push_data)
   );

   dbu_queue #(
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   dbu_back #(
      .PIXEL_BITS      (PIXEL_BITS),
      .COORD_FRAC_BITS (COORD_FRAC_BITS),
      .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_data       (pop_data),
      .inverse_scale  (inverse_scale_ff),
      .region_top_row (region_top_row_ff),
      .frame_width    (frame_width_ff),
      .frame_height   (frame_height_ff),
      .rsp            (rsp)
   );

endmodule

@@ hw/rtl/dbu_front.sv @@
`timescale 1ns / 1ps
module dbu_front #(
   parameter int PIXEL_BITS      = dbu_pkg::PIXEL_BITS_DEFAULT,
   parameter int COORD_FRAC_BITS = dbu_pkg::COORD_FRAC_BITS_DEFAULT
) (
   dbu_req_if.sink                             req,
   input  logic [dbu_pkg::SCORE_BITS-1:0]      min_score,
   input  logic [PIXEL_BITS-1:0]               left_pad,
   input  logic [PIXEL_BITS-1:0]               pad_top,
   output logic                                push_valid,
   input  logic                                push_ready,
   output logic [1+dbu_pkg::SCORE_BITS+4*(PIXEL_BITS+COORD_FRAC_BITS+2)-1:0] push_data
);
   import dbu_pkg::*;

   localparam int CW = PIXEL_BITS + COORD_FRAC_BITS;
   localparam int DW = CW + 2;

   logic                  keep_box;
   logic [SCORE_BITS-1:0] score_kept;
   logic [DW-1:0]         pad_x;
   logic [DW-1:0]         pad_y;
   logic signed [DW-1:0]  d_left;
   logic signed [DW-1:0]  d_top;
   logic signed [DW-1:0]  d_right;
   logic signed [DW-1:0]  d_bottom;

   // Score and class filtering happens here; the back end only sees the verdict.
   assign keep_box   = (req.confidence >= min_score) && (req.category == KEEP_CATEGORY);
   assign score_kept = keep_box ? req.confidence : '0;

   assign pad_x = DW'(left_pad) << COORD_FRAC_BITS;
   assign pad_y = DW'(pad_top) << COORD_FRAC_BITS;

   assign d_left   = $signed({{2{req.left_in[CW-1]}}, req.left_in})     - $signed(pad_x);
   assign d_top    = $signed({{2{req.top_in[CW-1]}}, req.top_in})       - $signed(pad_y);
   assign d_right  = $signed({{2{req.right_in[CW-1]}}, req.right_in})   - $signed(pad_x);
   assign d_bottom = $signed({{2{req.bottom_in[CW-1]}}, req.bottom_in}) - $signed(pad_y);

   assign push_valid = req.valid;
   assign req.ready  = push_ready;
   assign push_data  = {keep_box, score_kept, d_left, d_top, d_right, d_bottom};

endmodule

@@ hw/rtl/dbu_queue.sv @@
`timescale 1ns / 1ps
module dbu_queue #(
   parameter int WIDTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   import dbu_pkg::*;

   localparam int PTRW = $clog2(QUEUE_DEPTH);
   localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] entries_ff [QUEUE_DEPTH];
   logic [PTRW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTRW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;
   logic             push_fire;
   logic             pop_fire;

   assign push_ready = (count_ff != CNTW'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push_fire ? wr_ptr_ff + PTRW'(1) : wr_ptr_ff;
      rd_ptr_in = pop_fire ? rd_ptr_ff + PTRW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire && !pop_fire) begin
         count_in = count_ff + CNTW'(1);
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(QUEUE_DEPTH))
      else $error("queue occupancy exceeds its depth");

   a_push_only_grows: assert property (@(posedge clock) disable iff (reset)
      (push_fire && !pop_fire) |=> count_ff == $past(count_ff) + CNTW'(1))
      else $error("queue occupancy did not grow on a push");

   a_pointers_track_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers differ while empty");

endmodule

@@ hw/rtl/dbu_back.sv @@
`timescale 1ns / 1ps
module dbu_back #(
   parameter int PIXEL_BITS      = dbu_pkg::PIXEL_BITS_DEFAULT,
   parameter int COORD_FRAC_BITS = dbu_pkg::COORD_FRAC_BITS_DEFAULT,
   parameter int SCALE_FRAC_BITS = dbu_pkg::SCALE_FRAC_BITS_DEFAULT
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           pop_valid,
   output logic                                           pop_ready,
   input  logic [1+dbu_pkg::SCORE_BITS+4*(PIXEL_BITS+COORD_FRAC_BITS+2)-1:0] pop_data,
   input  logic [dbu_pkg::SCALE_INT_BITS+SCALE_FRAC_BITS-1:0] inverse_scale,
   input  logic [PIXEL_BITS-1:0]                          region_top_row,
   input  logic [PIXEL_BITS-1:0]                          frame_width,
   input  logic [PIXEL_BITS-1:0]                          frame_height,
   dbu_rsp_if.source                                      rsp
);
   import dbu_pkg::*;

   localparam int CW = PIXEL_BITS + COORD_FRAC_BITS;
   localparam int DW = CW + 2;
   localparam int SW = SCALE_INT_BITS + SCALE_FRAC_BITS;
   localparam int MW = DW + SW + 1;
   localparam int TF = COORD_FRAC_BITS + SCALE_FRAC_BITS;
   localparam int PW = MW + 1;
   localparam int RW = PW - TF;
   localparam int PB = PIXEL_BITS;

   // Rounds a value with TF fraction bits half away from zero and clamps it to
   // [0, hi]. A negative value always lands on zero, so only the positive side
   // needs the rounding bias.
   function automatic logic [PB-1:0] round_clamp(input logic signed [PW-1:0] p,
                                                 input logic [PB-1:0] hi);
      logic [PW-1:0] biased;
      logic [RW-1:0] whole;
      logic [PB-1:0] result;
      biased = p + (PW'(1) << (TF - 1));
      whole  = biased[PW-1:TF];
      if (p[PW-1]) begin
         result = '0;
      end else if (whole > RW'(hi)) begin
         result = hi;
      end else begin
         result = whole[PB-1:0];
      end
      return result;
   endfunction

   logic                  advance;
   logic                  q_keep;
   logic [SCORE_BITS-1:0] q_score;
   logic signed [DW-1:0]  q_left, q_top, q_right, q_bottom;
   logic [SW-1:0]         scale_eff;
   logic [PW-1:0]         offset_y;

   // Stage 1: scaled corners.
   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_keep_ff, s1_keep_in;
   logic [SCORE_BITS-1:0] s1_score_ff, s1_score_in;
   logic signed [MW-1:0]  s1_left_ff, s1_left_in;
   logic signed [MW-1:0]  s1_top_ff, s1_top_in;
   logic signed [MW-1:0]  s1_right_ff, s1_right_in;
   logic signed [MW-1:0]  s1_bottom_ff, s1_bottom_in;

   // Stage 2: rounded and clamped frame coordinates.
   logic                  s2_valid_ff, s2_valid_in;
   logic                  s2_keep_ff, s2_keep_in;
   logic [SCORE_BITS-1:0] s2_score_ff, s2_score_in;
   logic [PB-1:0]         s2_x1_ff, s2_x1_in;
   logic [PB-1:0]         s2_y1_ff, s2_y1_in;
   logic [PB-1:0]         s2_x2_ff, s2_x2_in;
   logic [PB-1:0]         s2_y2_ff, s2_y2_in;

   // Stage 3: output register.
   logic                  out_valid_ff, out_valid_in;
   logic                  out_kept_ff, out_kept_in;
   logic [PB-1:0]         out_left_ff, out_left_in;
   logic [PB-1:0]         out_top_ff, out_top_in;
   logic [PB-1:0]         out_width_ff, out_width_in;
   logic [PB-1:0]         out_height_ff, out_height_in;
   logic [2*PB-1:0]       out_area_ff, out_area_in;
   logic [PB:0]           out_mid_x_ff, out_mid_x_in;
   logic [PB:0]           out_mid_y_ff, out_mid_y_in;
   logic [SCORE_BITS-1:0] out_score_ff, out_score_in;

   logic                  nonempty;
   logic [PB-1:0]         span_x;
   logic [PB-1:0]         span_y;
   logic signed [MW-1:0]  scale_signed;

   // The whole pipeline moves together; it holds only while a result waits.
   assign advance   = !out_valid_ff || rsp.ready;
   assign pop_ready = advance;

   assign {q_keep, q_score, q_left, q_top, q_right, q_bottom} = pop_data;

   // A zero scale register means unit scale.
   assign scale_eff    = (inverse_scale == '0) ? (SW'(1) << SCALE_FRAC_BITS) : inverse_scale;
   assign offset_y     = PW'(region_top_row) << TF;
   assign scale_signed = $signed(MW'(scale_eff));

   always_comb begin
      s1_valid_in  = pop_valid;
      s1_keep_in   = q_keep;
      s1_score_in  = q_score;
      s1_left_in   = MW'(q_left) * scale_signed;
      s1_top_in    = MW'(q_top) * scale_signed;
      s1_right_in  = MW'(q_right) * scale_signed;
      s1_bottom_in = MW'(q_bottom) * scale_signed;
   end

   always_comb begin
      s2_valid_in = s1_valid_ff;
      s2_keep_in  = s1_keep_ff;
      s2_score_in = s1_score_ff;
      s2_x1_in = round_clamp($signed({s1_left_ff[MW-1], s1_left_ff}), frame_width);
      s2_x2_in = round_clamp($signed({s1_right_ff[MW-1], s1_right_ff}), frame_width);
      s2_y1_in = round_clamp($signed({s1_top_ff[MW-1], s1_top_ff}) + $signed(offset_y),
                             frame_height);
      s2_y2_in = round_clamp($signed({s1_bottom_ff[MW-1], s1_bottom_ff}) + $signed(offset_y),
                             frame_height);
   end

   always_comb begin
      nonempty = (s2_x2_ff > s2_x1_ff) && (s2_y2_ff > s2_y1_ff);
      span_x   = s2_x2_ff - s2_x1_ff;
      span_y   = s2_y2_ff - s2_y1_ff;

      out_valid_in  = s2_valid_ff;
      out_kept_in   = s2_keep_ff && nonempty;
      out_left_in   = '0;
      out_top_in    = '0;
      out_width_in  = '0;
      out_height_in = '0;
      out_area_in   = '0;
      out_mid_x_in  = '0;
      out_mid_y_in  = '0;
      out_score_in  = '0;
      if (out_kept_in) begin
         out_left_in   = s2_x1_ff;
         out_top_in    = s2_y1_ff;
         out_width_in  = span_x;
         out_height_in = span_y;
         out_area_in   = (2*PB)'(span_x) * (2*PB)'(span_y);
         out_mid_x_in  = (PB+1)'(s2_x1_ff) + (PB+1)'(span_x >> 1);
         out_mid_y_in  = (PB+1)'(s2_y1_ff) + (PB+1)'(span_y >> 1);
         out_score_in  = s2_score_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_keep_ff    <= s1_keep_in;
         s1_score_ff   <= s1_score_in;
         s1_left_ff    <= s1_left_in;
         s1_top_ff     <= s1_top_in;
         s1_right_ff   <= s1_right_in;
         s1_bottom_ff  <= s1_bottom_in;
         s2_keep_ff    <= s2_keep_in;
         s2_score_ff   <= s2_score_in;
         s2_x1_ff      <= s2_x1_in;
         s2_y1_ff      <= s2_y1_in;
         s2_x2_ff      <= s2_x2_in;
         s2_y2_ff      <= s2_y2_in;
         out_kept_ff   <= out_kept_in;
         out_left_ff   <= out_left_in;
         out_top_ff    <= out_top_in;
         out_width_ff  <= out_width_in;
         out_height_ff <= out_height_in;
         out_area_ff   <= out_area_in;
         out_mid_x_ff  <= out_mid_x_in;
         out_mid_y_ff  <= out_mid_y_in;
         out_score_ff  <= out_score_in;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.kept        = out_kept_ff;
   assign rsp.rect_left   = out_left_ff;
   assign rsp.rect_top    = out_top_ff;
   assign rsp.rect_width  = out_width_ff;
   assign rsp.rect_height = out_height_ff;
   assign rsp.rect_area   = out_area_ff;
   assign rsp.mid_x       = out_mid_x_ff;
   assign rsp.mid_y       = out_mid_y_ff;
   assign rsp.score_out   = out_score_ff;

   a_kept_not_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.kept) |-> (rsp.rect_width != '0) && (rsp.rect_height != '0))
      else $error("kept item with an empty rectangle");

   a_dropped_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.kept) |-> (rsp.score_out == '0) && (rsp.rect_area == '0)
                                   && (rsp.mid_x == '0) && (rsp.rect_left == '0))
      else $error("dropped item carries nonzero fields");

   a_stall_reaches_queue: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |-> !pop_ready)
      else $error("queue popped while the output is stalled");

endmodule

@@ bench/tb_detection_box_unletterbox.sv @@
`timescale 1ns / 1ps
module tb_detection_box_unletterbox;
   import dbu_pkg::*;

   localparam int CLOCK_PERIOD     = 10;
   localparam int PIX              = PIXEL_BITS_DEFAULT;
   localparam int COORD_BITS       = PIXEL_BITS_DEFAULT + COORD_FRAC_BITS_DEFAULT;
   localparam int FRAC_TOTAL       = COORD_FRAC_BITS_DEFAULT + SCALE_FRAC_BITS_DEFAULT;
   localparam int SCALE_BITS       = SCALE_INT_BITS + SCALE_FRAC_BITS_DEFAULT;
   localparam int CSR_DATA_BITS    = (SCALE_BITS > SCORE_BITS) ? SCALE_BITS : SCORE_BITS;
   localparam int COORD_MAX        = (1 << (COORD_BITS - 1)) - 1;
   localparam int COORD_MIN        = -(1 << (COORD_BITS - 1));
   localparam longint UNITY_SCALE  = longint'(1) << SCALE_FRAC_BITS_DEFAULT;
   localparam logic [CSR_INDEX_BITS-1:0] REG_UNMAPPED = 3'd7;
   localparam int SETTLE_CYCLES    = 8;
   localparam int IDLE_LIMIT       = 4000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int RANDOM_PHASES    = 6;
   localparam int ITEMS_PER_PHASE  = 190;

   typedef struct {
      logic signed [COORD_BITS-1:0] left_in;
      logic signed [COORD_BITS-1:0] top_in;
      logic signed [COORD_BITS-1:0] right_in;
      logic signed [COORD_BITS-1:0] bottom_in;
      logic [SCORE_BITS-1:0]        confidence;
      logic [CATEGORY_BITS-1:0]     category;
   } box_type;

   typedef struct {
      logic                 kept;
      logic [PIX-1:0]       rect_left;
      logic [PIX-1:0]       rect_top;
      logic [PIX-1:0]       rect_width;
      logic [PIX-1:0]       rect_height;
      logic [2*PIX-1:0]     rect_area;
      logic [PIX:0]         mid_x;
      logic [PIX:0]         mid_y;
      logic [SCORE_BITS-1:0] score_out;
   } rect_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_write_data;

   dbu_req_if req_bus ();
   dbu_rsp_if rsp_bus ();

   detection_box_unletterbox i_dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_bus),
      .rsp              (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Shadow copy of the configuration registers.
   logic [SCORE_BITS-1:0] cfg_threshold;
   logic [SCALE_BITS-1:0] cfg_inverse_scale;
   logic [PIX-1:0]        cfg_left_pad;
   logic [PIX-1:0]        cfg_pad_top;
   logic [PIX-1:0]        cfg_region_row;
   logic [PIX-1:0]        cfg_frame_width;
   logic [PIX-1:0]        cfg_frame_height;

   rect_type pending_rects[$];

   int  fail_count     = 0;
   int  items_sent     = 0;
   int  rects_kept     = 0;
   int  rects_dropped  = 0;
   int  settings_used  = 0;
   int  drain_pauses   = 0;
   int  hold_count     = 0;
   bit  idle_enabled   = 1'b1;
   bit  long_hold_request = 1'b0;
   bit  hold_active    = 1'b0;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic longint frame_coord(logic signed [COORD_BITS-1:0] corner,
                                          logic [PIX-1:0] pad, logic [PIX-1:0] row_offset,
                                          longint scale, longint upper);
      longint diff, prod, mag, whole;
      diff  = longint'(corner) - (longint'(pad) <<< COORD_FRAC_BITS_DEFAULT);
      prod  = diff * scale + (longint'(row_offset) <<< FRAC_TOTAL);
      mag   = (prod < 0) ? -prod : prod;
      whole = (mag + (longint'(1) <<< (FRAC_TOTAL - 1))) >>> FRAC_TOTAL;
      if (prod < 0) whole = -whole;
      if (whole > upper) whole = upper;
      if (whole < 0) whole = 0;
      return whole;
   endfunction

   function automatic rect_type unletterbox_box(box_type b);
      rect_type r;
      longint scale, x1, y1, x2, y2, w, h, area, cx, cy;
      r = '{default: '0};
      if (b.confidence < cfg_threshold || b.category != KEEP_CATEGORY) return r;
      scale = (cfg_inverse_scale == 0) ? UNITY_SCALE : longint'(cfg_inverse_scale);
      x1 = frame_coord(b.left_in, cfg_left_pad, '0, scale, longint'(cfg_frame_width));
      x2 = frame_coord(b.right_in, cfg_left_pad, '0, scale, longint'(cfg_frame_width));
      y1 = frame_coord(b.top_in, cfg_pad_top, cfg_region_row, scale,
                       longint'(cfg_frame_height));
      y2 = frame_coord(b.bottom_in, cfg_pad_top, cfg_region_row, scale,
                       longint'(cfg_frame_height));
      w = x2 - x1;
      h = y2 - y1;
      if (w <= 0 || h <= 0) return r;
      area = w * h;
      cx   = x1 + (w >>> 1);
      cy   = y1 + (h >>> 1);
      r.kept        = 1'b1;
      r.rect_left   = x1[PIX-1:0];
      r.rect_top    = y1[PIX-1:0];
      r.rect_width  = w[PIX-1:0];
      r.rect_height = h[PIX-1:0];
      r.rect_area   = area[2*PIX-1:0];
      r.mid_x       = cx[PIX:0];
      r.mid_y       = cy[PIX:0];
      r.score_out   = b.confidence;
      return r;
   endfunction

   function automatic int idle_gap();
      int pick;
      if (!idle_enabled) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [COORD_BITS-1:0] sat_coord(int v);
      if (v > COORD_MAX) v = COORD_MAX;
      if (v < COORD_MIN) v = COORD_MIN;
      return v[COORD_BITS-1:0];
   endfunction

   function automatic box_type make_box(int l, int t, int rgt, int btm, int conf, int cat);
      box_type b;
      b.left_in    = sat_coord(l);
      b.top_in     = sat_coord(t);
      b.right_in   = sat_coord(rgt);
      b.bottom_in  = sat_coord(btm);
      b.confidence = conf[SCORE_BITS-1:0];
      b.category   = cat[CATEGORY_BITS-1:0];
      return b;
   endfunction

   // Most boxes are plausible detections near the padded image; the rest are
   // near misses of the filters or pure noise.
   function automatic box_type random_box();
      box_type b;
      int   pick, x0, y0;
      logic signed [COORD_BITS-1:0] swap;
      pick = $urandom_range(0, 99);
      if (pick >= 85) begin
         b.left_in    = COORD_BITS'($urandom);
         b.top_in     = COORD_BITS'($urandom);
         b.right_in   = COORD_BITS'($urandom);
         b.bottom_in  = COORD_BITS'($urandom);
         b.confidence = SCORE_BITS'($urandom);
         b.category   = CATEGORY_BITS'($urandom);
         return b;
      end
      x0 = int'(cfg_left_pad) * 16 + int'($urandom_range(0, 16000)) - 2000;
      y0 = int'(cfg_pad_top) * 16 + int'($urandom_range(0, 16000)) - 2000;
      b.left_in    = sat_coord(x0);
      b.top_in     = sat_coord(y0);
      b.right_in   = sat_coord(x0 + int'($urandom_range(1, 6000)));
      b.bottom_in  = sat_coord(y0 + int'($urandom_range(1, 6000)));
      b.confidence = SCORE_BITS'($urandom_range(cfg_threshold, (1 << SCORE_BITS) - 1));
      b.category   = KEEP_CATEGORY;
      if (pick >= 70) begin
         case ($urandom_range(0, 2))
            0: begin
               if (cfg_threshold != 0)
                  b.confidence = SCORE_BITS'($urandom_range(0, cfg_threshold - 1));
            end
            1: begin
               b.category = CATEGORY_BITS'($urandom_range(1, (1 << CATEGORY_BITS) - 1));
            end
            default: begin
               swap       = b.left_in;
               b.left_in  = b.right_in;
               b.right_in = swap;
            end
         endcase
      end
      return b;
   endfunction

   task automatic write_csr(logic [CSR_INDEX_BITS-1:0] idx, int unsigned data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data[CSR_DATA_BITS-1:0];
      @(posedge clock);
      case (idx)
         REG_MIN_SCORE:      cfg_threshold     = data[SCORE_BITS-1:0];
         REG_INVERSE_SCALE:  cfg_inverse_scale = data[SCALE_BITS-1:0];
         REG_LEFT_PAD:       cfg_left_pad      = data[PIX-1:0];
         REG_PAD_TOP:        cfg_pad_top       = data[PIX-1:0];
         REG_REGION_TOP_ROW: cfg_region_row    = data[PIX-1:0];
         REG_FRAME_WIDTH:    cfg_frame_width   = data[PIX-1:0];
         REG_FRAME_HEIGHT:   cfg_frame_height  = data[PIX-1:0];
         default: ;
      endcase
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // Stop offering items and wait until every outstanding result is back.
   task automatic finish_outstanding();
      req_bus.valid <= 1'b0;
      while (pending_rects.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      drain_pauses++;
   endtask

   task automatic apply_setting(int unsigned thr, int unsigned scale, int unsigned pl,
                                int unsigned pt, int unsigned row, int unsigned fw,
                                int unsigned fh);
      finish_outstanding();
      write_csr(REG_MIN_SCORE, thr);
      write_csr(REG_INVERSE_SCALE, scale);
      write_csr(REG_LEFT_PAD, pl);
      write_csr(REG_PAD_TOP, pt);
      write_csr(REG_REGION_TOP_ROW, row);
      write_csr(REG_FRAME_WIDTH, fw);
      write_csr(REG_FRAME_HEIGHT, fh);
      settings_used++;
   endtask

   // Valid stays high after acceptance so back-to-back items need no extra edge.
   task automatic send_box(box_type b);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.left_in    <= b.left_in;
      req_bus.top_in     <= b.top_in;
      req_bus.right_in   <= b.right_in;
      req_bus.bottom_in  <= b.bottom_in;
      req_bus.confidence <= b.confidence;
      req_bus.category   <= b.category;
      do @(posedge clock); while (!req_bus.ready);
      pending_rects.insert(pending_rects.size(), unletterbox_box(b));
      items_sent++;
   endtask

   task automatic test_default_filters();
      send_box(make_box(160, 320, 1600, 2400, 40000, 0));
      // Score exactly at the threshold is kept, one below is not.
      send_box(make_box(160, 320, 1600, 2400, 16384, 0));
      send_box(make_box(160, 320, 1600, 2400, 16383, 0));
      send_box(make_box(160, 320, 1600, 2400, 65535, 1));
      send_box(make_box(160, 320, 1600, 2400, 65535, 255));
      send_box(make_box(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 65535, 0));
      send_box(make_box(1600, 320, 160, 2400, 50000, 0));
      send_box(make_box(800, 320, 800, 2400, 50000, 0));
      // Half a pixel rounds away from zero; just under half rounds down.
      send_box(make_box(8, 7, 24, 9, 30000, 0));
      send_box(make_box(160, 320, 1600, 2400, 0, 0));
   endtask

   task automatic test_register_extremes();
      // A zero scale acts as unity; a zero threshold keeps a zero score.
      apply_setting(0, 0, 0, 0, 0, 4095, 4095);
      send_box(make_box(0, 0, 16, 16, 0, 0));
      send_box(make_box(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 1, 0));
      // Largest scale and padding push every corner off the frame.
      apply_setting(65535, 1048575, 4095, 4095, 4095, 4095, 4095);
      send_box(make_box(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 65535, 0));
      send_box(make_box(0, 0, COORD_MAX, COORD_MAX, 65534, 0));
      apply_setting(0, 1048575, 0, 0, 2000, 4095, 4095);
      send_box(make_box(16, 16, 160, 32, 12345, 0));
      // The smallest scale squeezes every box into the origin.
      apply_setting(0, 1, 0, 0, 0, 4095, 4095);
      send_box(make_box(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 100, 0));
      // A frame of zero size leaves nothing to keep.
      apply_setting(0, 65536, 0, 0, 100, 0, 0);
      send_box(make_box(0, 0, 3200, 3200, 100, 0));
      apply_setting(0, 65536, 0, 0, 0, 1, 1);
      send_box(make_box(-16, -16, 320, 320, 100, 0));
      // A write to an unmapped index must leave every register alone.
      finish_outstanding();
      write_csr(REG_UNMAPPED, 20'hFFFFF);
      send_box(make_box(0, 0, 32, 32, 0, 0));
   endtask

   task automatic test_random_boxes();
      int unsigned thr, scale, pl, pt, row, fw, fh;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(0, 3))
            0:       thr = 0;
            1:       thr = $urandom_range(0, 65535);
            default: thr = $urandom_range(0, 32768);
         endcase
         scale = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 20'hFFFFF)
                                             : $urandom_range(16384, 262144);
         pl    = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 128);
         pt    = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 128);
         row   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 512);
         fw    = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) : $urandom_range(256, 4095);
         fh    = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) : $urandom_range(256, 4095);
         apply_setting(thr, scale, pl, pt, row, fw, fh);
         // One phase runs flat out with no gaps on either side.
         idle_enabled = (phase != 2);
         for (int i = 0; i < ITEMS_PER_PHASE; i++) send_box(random_box());
      end
      idle_enabled = 1'b1;
   endtask

   task automatic test_output_backpressure();
      apply_setting(8192, 65536, 0, 0, 0, 640, 480);
      idle_enabled = 1'b0;
      long_hold_request = 1'b1;
      while (!hold_active) @(posedge clock);
      // The block fills while the receiver holds off and must stall its input.
      for (int i = 0; i < 60; i++) send_box(random_box());
      idle_enabled = 1'b1;
   endtask

   initial begin : rsp_ready_driver
      int stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            hold_active = 1'b1;
            hold_count++;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            hold_active = 1'b0;
         end else begin
            stall = idle_gap();
            if (stall > 0) begin
               rsp_bus.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end else begin
               rsp_bus.ready <= 1'b1;
               repeat ($urandom_range(1, 6)) @(posedge clock);
            end
         end
      end
   end

   task automatic check_field(string field, longint expected, longint actual);
      if (expected != actual) begin
         $error("%s: expected %0d, actual %0d", field, expected, actual);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : rect_checker
      rect_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_rects.size() == 0) begin
            $error("result item arrived with no box outstanding");
            fail_count++;
         end else begin
            want = pending_rects.pop_front();
            check_field("kept", want.kept, rsp_bus.kept);
            check_field("rect_left", want.rect_left, rsp_bus.rect_left);
            check_field("rect_top", want.rect_top, rsp_bus.rect_top);
            check_field("rect_width", want.rect_width, rsp_bus.rect_width);
            check_field("rect_height", want.rect_height, rsp_bus.rect_height);
            check_field("rect_area", want.rect_area, rsp_bus.rect_area);
            check_field("mid_x", want.mid_x, rsp_bus.mid_x);
            check_field("mid_y", want.mid_y, rsp_bus.mid_y);
            check_field("score_out", want.score_out, rsp_bus.score_out);
            if (want.kept) rects_kept++;
            else rects_dropped++;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      int quiet_cycles;
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("FAIL detection_box_unletterbox");
         $finish;
      end
   end

   initial begin
      cfg_threshold     = SCORE_BITS'(MIN_SCORE_RESET);
      cfg_inverse_scale = SCALE_BITS'(UNITY_SCALE);
      cfg_left_pad      = '0;
      cfg_pad_top       = '0;
      cfg_region_row    = '0;
      cfg_frame_width   = PIX'(FRAME_SIZE_RESET);
      cfg_frame_height  = PIX'(FRAME_SIZE_RESET);
      reset              <= 1'b1;
      csr_write_enable   <= 1'b0;
      csr_index          <= '0;
      csr_write_data     <= '0;
      req_bus.valid      <= 1'b0;
      req_bus.left_in    <= '0;
      req_bus.top_in     <= '0;
      req_bus.right_in   <= '0;
      req_bus.bottom_in  <= '0;
      req_bus.confidence <= '0;
      req_bus.category   <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_default_filters();
      test_register_extremes();
      test_random_boxes();
      test_output_backpressure();
      finish_outstanding();

      $display("Checked %0d boxes (%0d kept, %0d dropped) under %0d register settings.",
               items_sent, rects_kept, rects_dropped, settings_used);
      $display("Receiver held off %0d time(s) for %0d cycles; sender drained %0d times.",
               hold_count, LONG_HOLD_CYCLES, drain_pauses);
      if (fail_count == 0) begin
         $display("PASS detection_box_unletterbox");
      end else begin
         $display("FAIL detection_box_unletterbox");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/dbu_pkg.sv
hw/rtl/dbu_if.sv
hw/rtl/dbu_front.sv
hw/rtl/dbu_queue.sv
hw/rtl/dbu_back.sv
hw/rtl/detection_box_unletterbox.sv
bench/tb_detection_box_unletterbox.sv
